// ===== rtl/ycc2rgb_pkg.sv =====
// Shared types and constants for the Y'CbCr to RGB pixel converter.
package ycc2rgb_pkg;

  localparam int TableDepth = 256;
  localparam int TableAw    = $clog2(TableDepth);
  localparam int PixW       = 8;
  localparam int GainW      = 18;
  localparam int RangeW     = 17;
  localparam int InDataW    = 56;
  localparam int OutDataW   = 3 * PixW;
  localparam int UserW      = 2;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 18;
  localparam int MatDepth   = 9;
  localparam int MatAw      = $clog2(MatDepth);
  localparam int NumStages  = 9;
  localparam int LumaLow    = 16;
  localparam int LumaHigh   = 235;
  localparam int PixMax     = 255;

  localparam logic signed [GainW-1:0] CrToRedRst   = 18'sd44916;
  localparam logic signed [GainW-1:0] CbToGreenRst = -18'sd11025;
  localparam logic signed [GainW-1:0] CrToGreenRst = -18'sd22879;
  localparam logic signed [GainW-1:0] CbToBlueRst  = 18'sd56771;
  localparam logic [PixW-1:0]         BlackRst     = 8'd16;
  localparam logic [PixW-1:0]         CenterRst    = 8'd128;
  localparam logic [RangeW-1:0]       RangeGainRst = 17'd38304;

  typedef enum logic [UserW-1:0] {
    OP_CONVERT,
    OP_TABLE,
    OP_MATRIX,
    OP_NONE
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LUMA_ONLY,
    CFG_CR_TO_RED,
    CFG_CB_TO_GREEN,
    CFG_CR_TO_GREEN,
    CFG_CB_TO_BLUE,
    CFG_BLACK_OFFSET,
    CFG_CHROMA_CENTER,
    CFG_RANGE_GAIN
  } cfg_reg_e;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [TableAw-1:0] addr;
    logic [PixW-1:0]    wdata;
  } lut_req_t;

  typedef struct packed {
    logic                    mat;
    logic                    ok;
    logic [MatAw-1:0]        idx;
    logic signed [GainW-1:0] val;
  } mat_ld_t;

endpackage

// ===== rtl/ycbcr_to_rgb_pixel_converter_unit.sv =====
// Y'CbCr to RGB pixel converter: nine-stage pipeline, one item per clock
// unless the output stalls. It returns one RGB pixel per accepted convert
// item; table and matrix load items produce no pixel. Throughput is set by
// the pipeline alone: each stage holds one layer of multipliers or of adds
// and compares, the luma table is a single-port memory read or written once
// per accepted item, and the matrix is a register file. A matrix load takes
// effect in program order as it passes stage six. A stall at the output
// backs up only the occupied stages; bubbles are squeezed out.
module ycbcr_to_rgb_pixel_converter_unit #(
  parameter int FRAC_BITS = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // luma[7:0], blue_diff[15:8], red_diff[23:16], load_index[31:24],
  // load_value[49:32], zero fill
  input  logic [ycc2rgb_pkg::InDataW-1:0]     s_axis_tdata_i,
  // operation[1:0]
  input  logic [ycc2rgb_pkg::UserW-1:0]       s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // red[7:0], green[15:8], blue[23:16]
  output logic [ycc2rgb_pkg::OutDataW-1:0]    m_axis_tdata_o,
  input  logic                                cfg_we_i,
  input  logic [ycc2rgb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ycc2rgb_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int NS    = ycc2rgb_pkg::NumStages;
  localparam int Half  = 1 << (FRAC_BITS - 1);
  localparam int SumW  = 28;
  localparam int ChW   = 30 - FRAC_BITS;
  localparam int LinPW = 27;
  localparam int LinW  = 28 - FRAC_BITS;
  localparam int MpW   = LinW + ycc2rgb_pkg::GainW;
  localparam int AccW  = MpW + 2;

  // configuration registers
  logic                    luma_only_q;
  logic signed [17:0]      cr_red_q, cb_green_q, cr_green_q, cb_blue_q;
  logic [7:0]              black_q, center_q;
  logic [16:0]             range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_only_q <= 1'b0;
      cr_red_q    <= ycc2rgb_pkg::CrToRedRst;
      cb_green_q  <= ycc2rgb_pkg::CbToGreenRst;
      cr_green_q  <= ycc2rgb_pkg::CrToGreenRst;
      cb_blue_q   <= ycc2rgb_pkg::CbToBlueRst;
      black_q     <= ycc2rgb_pkg::BlackRst;
      center_q    <= ycc2rgb_pkg::CenterRst;
      range_q     <= ycc2rgb_pkg::RangeGainRst;
    end else if (cfg_we_i) begin
      unique case (ycc2rgb_pkg::cfg_reg_e'(cfg_index_i))
        ycc2rgb_pkg::CFG_LUMA_ONLY:     luma_only_q <= cfg_data_i[0];
        ycc2rgb_pkg::CFG_CR_TO_RED:     cr_red_q    <= $signed(cfg_data_i);
        ycc2rgb_pkg::CFG_CB_TO_GREEN:   cb_green_q  <= $signed(cfg_data_i);
        ycc2rgb_pkg::CFG_CR_TO_GREEN:   cr_green_q  <= $signed(cfg_data_i);
        ycc2rgb_pkg::CFG_CB_TO_BLUE:    cb_blue_q   <= $signed(cfg_data_i);
        ycc2rgb_pkg::CFG_BLACK_OFFSET:  black_q     <= cfg_data_i[7:0];
        ycc2rgb_pkg::CFG_CHROMA_CENTER: center_q    <= cfg_data_i[7:0];
        ycc2rgb_pkg::CFG_RANGE_GAIN:    range_q     <= cfg_data_i[16:0];
        default:                        luma_only_q <= luma_only_q;
      endcase
    end
  end

  // pipeline control
  logic [NS:1] valid_q, valid_d, en;
  logic        accept;
  ycc2rgb_pkg::op_e in_op;

  assign in_op  = ycc2rgb_pkg::op_e'(s_axis_tuser_i);
  assign accept = s_axis_tvalid_i && en[1];
  assign s_axis_tready_o = en[1];

  always_comb begin
    en[NS] = !valid_q[NS] || m_axis_tready_i;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  ycc2rgb_pkg::mat_ld_t ld_q [1:6];

  always_comb begin
    valid_d[1] = s_axis_tvalid_i &&
                 (in_op == ycc2rgb_pkg::OP_CONVERT || in_op == ycc2rgb_pkg::OP_MATRIX);
    for (int k = 2; k <= NS; k++) begin
      valid_d[k] = valid_q[k-1];
    end
    // drop matrix loads once applied
    valid_d[7] = valid_q[6] && !ld_q[6].mat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  // stage 1: table access
  ycc2rgb_pkg::lut_req_t lut_req;
  logic [7:0]            y1;

  always_comb begin
    lut_req.we    = accept && in_op == ycc2rgb_pkg::OP_TABLE;
    lut_req.re    = accept && in_op == ycc2rgb_pkg::OP_CONVERT;
    lut_req.addr  = lut_req.we ? s_axis_tdata_i[31:24] : s_axis_tdata_i[7:0];
    lut_req.wdata = s_axis_tdata_i[39:32];
  end

  ycc2rgb_lut u_lut (
    .clk_i   (clk_i),
    .req_i   (lut_req),
    .rdata_o (y1)
  );

  logic [7:0]              cb1_q, cr1_q;
  logic [7:0]              y_q [2:NS];
  logic signed [26:0]      pr2_q, pgb2_q, pgr2_q, pb2_q;
  logic signed [ChW-1:0]   ch3_q [3];
  logic signed [8:0]       d4_q [3];
  logic signed [LinPW-1:0] pl5_q [3];
  logic signed [LinW-1:0]  lin6_q [3];
  logic signed [MpW-1:0]   mp7_q [3][3];
  logic signed [AccW-1:0]  acc8_q [3];
  logic [7:0]              rgb9_q [3];
  logic signed [17:0]      mat_q [ycc2rgb_pkg::MatDepth];

  // stage 2: centered chroma times gains
  logic signed [8:0] u2, v2;
  assign u2 = $signed({1'b0, cb1_q}) - $signed({1'b0, center_q});
  assign v2 = $signed({1'b0, cr1_q}) - $signed({1'b0, center_q});

  // stage 3: round and add luma
  logic signed [SumW-1:0] sum3 [3];
  logic signed [SumW-1:0] rnd3 [3];
  logic signed [ChW-1:0]  ch3_d [3];

  always_comb begin
    sum3[0] = SumW'(pr2_q);
    sum3[1] = SumW'(pgb2_q) + SumW'(pgr2_q);
    sum3[2] = SumW'(pb2_q);
    for (int c = 0; c < 3; c++) begin
      rnd3[c]  = (sum3[c] + SumW'(Half)) >>> FRAC_BITS;
      ch3_d[c] = ChW'(rnd3[c]) + ChW'($signed({1'b0, y_q[2]}));
    end
  end

  // stage 4: clamp to video range, remove black level
  logic [7:0]        cl4 [3];
  logic signed [8:0] d4_d [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      priority if (ch3_q[c] < ChW'(ycc2rgb_pkg::LumaLow)) begin
        cl4[c] = 8'(ycc2rgb_pkg::LumaLow);
      end else if (ch3_q[c] > ChW'(ycc2rgb_pkg::LumaHigh)) begin
        cl4[c] = 8'(ycc2rgb_pkg::LumaHigh);
      end else begin
        cl4[c] = ch3_q[c][7:0];
      end
      d4_d[c] = $signed({1'b0, cl4[c]}) - $signed({1'b0, black_q});
    end
  end

  // stage 6: round range expansion
  logic signed [LinPW:0] t6 [3];
  logic signed [LinPW:0] sh6 [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t6[c]  = (LinPW+1)'(pl5_q[c]) + (LinPW+1)'(Half);
      sh6[c] = t6[c] >>> FRAC_BITS;
    end
  end

  // stage 9: round and clamp to full range
  logic signed [AccW:0] t9 [3];
  logic signed [AccW:0] sh9 [3];
  logic [7:0]           rgb9_d [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t9[c]  = (AccW+1)'(acc8_q[c]) + (AccW+1)'(Half);
      sh9[c] = t9[c] >>> FRAC_BITS;
      priority if (sh9[c] < 0) begin
        rgb9_d[c] = 8'd0;
      end else if (sh9[c] > (AccW+1)'(ycc2rgb_pkg::PixMax)) begin
        rgb9_d[c] = 8'(ycc2rgb_pkg::PixMax);
      end else begin
        rgb9_d[c] = sh9[c][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cb1_q        <= s_axis_tdata_i[15:8];
      cr1_q        <= s_axis_tdata_i[23:16];
      ld_q[1].mat  <= in_op == ycc2rgb_pkg::OP_MATRIX;
      ld_q[1].ok   <= s_axis_tdata_i[31:24] < 8'(ycc2rgb_pkg::MatDepth);
      ld_q[1].idx  <= s_axis_tdata_i[24 +: ycc2rgb_pkg::MatAw];
      ld_q[1].val  <= $signed(s_axis_tdata_i[49:32]);
    end
    if (en[2]) begin
      y_q[2]  <= y1;
      ld_q[2] <= ld_q[1];
      pr2_q   <= v2 * cr_red_q;
      pgb2_q  <= u2 * cb_green_q;
      pgr2_q  <= v2 * cr_green_q;
      pb2_q   <= u2 * cb_blue_q;
    end
    if (en[3]) begin
      y_q[3]  <= y_q[2];
      ld_q[3] <= ld_q[2];
      ch3_q   <= ch3_d;
    end
    if (en[4]) begin
      y_q[4]  <= y_q[3];
      ld_q[4] <= ld_q[3];
      d4_q    <= d4_d;
    end
    if (en[5]) begin
      y_q[5]  <= y_q[4];
      ld_q[5] <= ld_q[4];
      for (int c = 0; c < 3; c++) begin
        pl5_q[c] <= d4_q[c] * $signed({1'b0, range_q});
      end
    end
    if (en[6]) begin
      y_q[6]  <= y_q[5];
      ld_q[6] <= ld_q[5];
      for (int c = 0; c < 3; c++) begin
        lin6_q[c] <= sh6[c][LinW-1:0];
      end
    end
    if (en[7]) begin
      y_q[7] <= y_q[6];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mp7_q[i][j] <= lin6_q[j] * mat_q[i*3+j];
        end
      end
    end
    if (en[8]) begin
      y_q[8] <= y_q[7];
      for (int i = 0; i < 3; i++) begin
        acc8_q[i] <= AccW'(mp7_q[i][0]) + AccW'(mp7_q[i][1]) + AccW'(mp7_q[i][2]);
      end
    end
    if (en[9]) begin
      y_q[9] <= y_q[8];
      rgb9_q <= rgb9_d;
    end
  end

  // apply matrix loads in order as they pass stage six
  always_ff @(posedge clk_i) begin
    if (valid_q[6] && ld_q[6].mat && ld_q[6].ok) begin
      mat_q[ld_q[6].idx] <= ld_q[6].val;
    end
  end

  assign m_axis_tvalid_o = valid_q[NS];
  assign m_axis_tdata_o  = luma_only_q ? {y_q[NS], y_q[NS], y_q[NS]}
                                       : {rgb9_q[2], rgb9_q[1], rgb9_q[0]};

`ifndef SYNTHESIS
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[NS] |-> s_axis_tready_o)
    else $error("input stalled with empty output stage");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q[NS]) |-> $past(valid_q[NS-1]))
    else $error("output item appeared without a predecessor");

  a_luma_only_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && luma_only_q) |->
      (m_axis_tdata_o[7:0] == m_axis_tdata_o[15:8] &&
       m_axis_tdata_o[15:8] == m_axis_tdata_o[23:16]))
    else $error("luma-only item has unequal channels");
`endif

endmodule

// ===== rtl/ycc2rgb_lut.sv =====
// Luma transfer table: single-port memory with registered read.
module ycc2rgb_lut (
  input  logic                  clk_i,
  input  ycc2rgb_pkg::lut_req_t req_i,
  output logic [ycc2rgb_pkg::PixW-1:0] rdata_o
);

  logic [ycc2rgb_pkg::PixW-1:0] mem_q [ycc2rgb_pkg::TableDepth];
  logic [ycc2rgb_pkg::PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
